// File: rtl/lhm_pkg.sv
// Shared types and constants for the latency histogram monitor.
`timescale 1ns / 1ps
package lhm_pkg;

  // operation codes carried by the input word
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int BIN_COUNT_DEF   = 2049;
  localparam int BIN_STEP_NS_DEF = 10000;

  // bin index field wide enough for the largest supported bin count
  localparam int BIN_W = 17;

  localparam logic [18:0] RATE_RESET = 19'd48000;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // one job handed from the front to the back
  typedef struct packed {
    logic [1:0]       op;
    logic [BIN_W-1:0] bin;
    logic [31:0]      dur;
    logic [15:0]      frm;
    logic             half_hit;
    logic             full_hit;
  } job_t;

endpackage

// File: rtl/lhm_front.sv
// Front end: accepts input words, finds the histogram bin and period hits.
`timescale 1ns / 1ps
module lhm_front #(
  parameter int BIN_COUNT   = lhm_pkg::BIN_COUNT_DEF,
  parameter int BIN_STEP_NS = lhm_pkg::BIN_STEP_NS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [18:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [31:0]       in_duration_ns,
  input  logic [15:0]       in_frames,
  input  logic              q_full,
  output logic              q_push,
  output lhm_pkg::job_t     q_data
);

  // reciprocal of the bin step, exact for every 32-bit duration
  localparam int RECIP_SH = 32 + $clog2(BIN_STEP_NS);
  localparam logic [32:0] RECIP = 33'(((64'd1 << RECIP_SH) + 64'(BIN_STEP_NS) - 64'd1) /
                                      64'(BIN_STEP_NS));
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [18:0] rate_r;
  logic [31:0] quo_r;
  logic [31:0] dur_r;
  logic [15:0] frm_r;
  logic [52:0] mul_full_r, mul_half_r, rhs_r;
  logic [64:0] quo_prod;
  logic        accept;
  logic [lhm_pkg::BIN_W-1:0] bin;

  assign in_stall = (state_r != F_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;

  // hold the sample rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= lhm_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  // bin index by reciprocal multiplication
  assign quo_prod = 65'(dur_r) * 65'(RECIP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept && in_op == lhm_pkg::OP_RECORD) state_nxt = F_DIV;
      F_DIV:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: latch the word, form quotient and period products
  always_ff @(posedge clk) begin
    if (accept) begin
      dur_r <= in_duration_ns;
      frm_r <= in_frames;
    end else if (state_r == F_DIV) begin
      quo_r      <= 32'(quo_prod >> RECIP_SH);
      mul_full_r <= 53'(({1'b0, dur_r} + 33'd1) * 33'(rate_r));
      mul_half_r <= 53'(({dur_r, 1'b1}) * 33'(rate_r));
      rhs_r      <= 53'(lhm_pkg::NS_PER_SEC * 46'(frm_r));
    end
  end

  // clamp the quotient to the last bin
  assign bin = (quo_r > 32'(BIN_COUNT - 1)) ? lhm_pkg::BIN_W'(BIN_COUNT - 1)
                                           : quo_r[lhm_pkg::BIN_W-1:0];

  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    if (state_r == F_PUSH) begin
      q_push          = !q_full;
      q_data.op       = lhm_pkg::OP_RECORD;
      q_data.bin      = bin;
      q_data.dur      = dur_r;
      q_data.frm      = frm_r;
      q_data.half_hit = (rate_r != '0) && (mul_half_r > rhs_r);
      q_data.full_hit = (rate_r != '0) && (mul_full_r > rhs_r);
    end else if (accept && (in_op == lhm_pkg::OP_QUERY || in_op == lhm_pkg::OP_CLEAR)) begin
      q_push    = 1'b1;
      q_data.op = in_op;
    end
  end

endmodule

// File: rtl/lhm_queue.sv
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module lhm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lhm_pkg::job_t push_data,
  input  logic          pop,
  output lhm_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  lhm_pkg::job_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = slot_r[rp_r];

  // store on push
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/lhm_back.sv
// Back end: histogram memory, statistics, percentile walk and mean divider.
`timescale 1ns / 1ps
module lhm_back #(
  parameter int BIN_COUNT   = lhm_pkg::BIN_COUNT_DEF,
  parameter int BIN_STEP_NS = lhm_pkg::BIN_STEP_NS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lhm_pkg::job_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_total_count,
  output logic [31:0]   out_mean_ns,
  output logic [24:0]   out_p99_upper_ns,
  output logic [31:0]   out_max_ns,
  output logic [15:0]   out_min_frames,
  output logic [15:0]   out_max_frames,
  output logic [31:0]   out_over_half_count,
  output logic [31:0]   out_over_full_count
);

  localparam int IDXW = $clog2(BIN_COUNT);
  localparam int RUNW = 32 + IDXW;
  localparam int CW   = RUNW + 7;
  localparam int PW   = IDXW + 21;
  localparam logic [63:0] P99_ALL = 64'(BIN_COUNT) * 64'(BIN_STEP_NS);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RRD   = 3'd2;
  localparam logic [2:0] S_RWR   = 3'd3;
  localparam logic [2:0] S_WRD   = 3'd4;
  localparam logic [2:0] S_WADD  = 3'd5;
  localparam logic [2:0] S_WCMP  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]      state_r;
  lhm_pkg::job_t   job_r;
  logic [IDXW-1:0] idx_r;
  logic [31:0]     mem [BIN_COUNT];
  logic [31:0]     rdata_r;
  logic [IDXW-1:0] rd_addr, wr_addr;
  logic            we;
  logic [31:0]     wdata;
  logic [RUNW-1:0] run_r;
  logic [38:0]     c99_r;
  logic [24:0]     p99_r;
  logic [31:0]     count_r, maxd_r, half_r, full_r;
  logic [63:0]     sum_r;
  logic [64:0]     sum_add;
  logic [15:0]     minf_r, maxf_r;
  logic            div_busy_r;
  logic [5:0]      div_cnt_r;
  logic [32:0]     div_rem_r, div_sh;
  logic [63:0]     div_quo_r;
  logic            div_ge;
  logic            slot_free;
  logic            last_bin;

  assign slot_free = !out_valid || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign last_bin  = idx_r == IDXW'(BIN_COUNT - 1);
  assign sum_add   = {1'b0, sum_r} + 65'(job_r.dur);

  // memory port selection
  always_comb begin
    rd_addr = (state_r == S_RRD) ? job_r.bin[IDXW-1:0] : idx_r;
    wr_addr = (state_r == S_RWR) ? job_r.bin[IDXW-1:0] : idx_r;
    we      = (state_r == S_SWEEP) || (state_r == S_RWR);
    wdata   = (state_r == S_RWR) ? ((rdata_r == '1) ? rdata_r : rdata_r + 32'd1) : '0;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (we) mem[wr_addr] <= wdata;
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      idx_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
      maxd_r  <= '0;
      minf_r  <= '1;
      maxf_r  <= '0;
      half_r  <= '0;
      full_r  <= '0;
    end else begin
      unique case (state_r)
        S_SWEEP: begin
          idx_r <= idx_r + IDXW'(1);
          if (last_bin) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: if (!q_empty) begin
          job_r <= q_head;
          idx_r <= '0;
          run_r <= '0;
          c99_r <= 39'(q_head.op == q_head.op) * 39'd0 + 39'(count_r) * 39'd99;
          case (q_head.op)
            lhm_pkg::OP_RECORD: state_r <= S_RRD;
            lhm_pkg::OP_QUERY:  state_r <= (count_r == '0) ? S_FIN : S_WRD;
            default: begin
              state_r <= S_SWEEP;
              count_r <= '0;
              sum_r   <= '0;
              maxd_r  <= '0;
              minf_r  <= '1;
              maxf_r  <= '0;
              half_r  <= '0;
              full_r  <= '0;
            end
          endcase
        end
        S_RRD: state_r <= S_RWR;
        S_RWR: begin
          if (count_r != '1) count_r <= count_r + 32'd1;
          sum_r <= sum_add[64] ? '1 : sum_add[63:0];
          if (job_r.dur > maxd_r) maxd_r <= job_r.dur;
          if (job_r.frm < minf_r) minf_r <= job_r.frm;
          if (job_r.frm > maxf_r) maxf_r <= job_r.frm;
          if (job_r.half_hit && half_r != '1) half_r <= half_r + 32'd1;
          if (job_r.full_hit && full_r != '1) full_r <= full_r + 32'd1;
          state_r <= S_IDLE;
        end
        S_WRD:  state_r <= S_WADD;
        S_WADD: begin
          run_r   <= run_r + RUNW'(rdata_r);
          state_r <= S_WCMP;
        end
        S_WCMP: begin
          if (CW'(run_r) * CW'(100) >= CW'(c99_r)) begin
            p99_r   <= 25'((PW'(idx_r) + PW'(1)) * PW'(BIN_STEP_NS));
            state_r <= S_FIN;
          end else if (last_bin) begin
            p99_r   <= P99_ALL[24:0];
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + IDXW'(1);
            state_r <= S_WRD;
          end
        end
        S_FIN: if (!div_busy_r && slot_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // mean divider: one quotient bit per cycle
  assign div_sh = {div_rem_r[31:0], div_quo_r[63]};
  assign div_ge = div_sh >= {1'b0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (state_r == S_IDLE && !q_empty && q_head.op == lhm_pkg::OP_QUERY &&
                 count_r != '0) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      div_rem_r  <= '0;
      div_quo_r  <= sum_r;
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? div_sh - {1'b0, count_r} : div_sh;
      div_quo_r <= {div_quo_r[62:0], div_ge};
      div_cnt_r <= div_cnt_r + 6'd1;
      if (div_cnt_r == 6'd63) div_busy_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_FIN && !div_busy_r && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && !div_busy_r && slot_free) begin
      out_total_count     <= count_r;
      out_max_ns          <= maxd_r;
      out_over_half_count <= half_r;
      out_over_full_count <= full_r;
      if (count_r == '0) begin
        out_mean_ns      <= '0;
        out_p99_upper_ns <= '0;
        out_min_frames   <= '0;
        out_max_frames   <= '0;
      end else begin
        out_mean_ns      <= (div_quo_r[63:32] != '0) ? '1 : div_quo_r[31:0];
        out_p99_upper_ns <= p99_r;
        out_min_frames   <= minf_r;
        out_max_frames   <= maxf_r;
      end
    end
  end

endmodule

// File: rtl/latency_histogram_monitor.sv
// Top level of the latency histogram monitor.
//
// Input channel in_*: one word per operation; op record adds a duration and
// frame count, op query asks for a summary word on out_*, op clear wipes all
// metrics (sample rate kept). A record passes through the front as accept,
// one reciprocal multiply for the bin index and period products, and push,
// and through the back as a memory read-modify-write. A query walks the bin
// memory bin by bin (read, add, compare) up to the percentile bin; with a
// non-empty history its summary word also waits for the mean divider, which
// runs alongside the walk. A clear sweeps the memory, zeroing every bin.
// A two-entry queue parts front and back, so the front keeps accepting while
// the back works or a summary waits in the output register.
// Reset (rst_n low, synchronous) clears control state and starts a clearing
// pass over every bin; words are queued meanwhile and run after it.
// While out_stall is high the summary word holds; a further summary waits
// in the back, and in_stall rises once the queue fills.
// cfg_we writes sample_rate; write it only while the block is idle.
`timescale 1ns / 1ps
module latency_histogram_monitor #(
  parameter int BIN_COUNT   = lhm_pkg::BIN_COUNT_DEF,
  parameter int BIN_STEP_NS = lhm_pkg::BIN_STEP_NS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [18:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_duration_ns,
  input  logic [15:0] in_frames,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_total_count,
  output logic [31:0] out_mean_ns,
  output logic [24:0] out_p99_upper_ns,
  output logic [31:0] out_max_ns,
  output logic [15:0] out_min_frames,
  output logic [15:0] out_max_frames,
  output logic [31:0] out_over_half_count,
  output logic [31:0] out_over_full_count
);

  lhm_pkg::job_t push_data, head;
  logic push, pop, full, empty;

  lhm_front #(.BIN_COUNT(BIN_COUNT), .BIN_STEP_NS(BIN_STEP_NS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_op,
    .in_duration_ns, .in_frames, .q_full(full), .q_push(push), .q_data(push_data)
  );

  lhm_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head, .full, .empty
  );

  lhm_back #(.BIN_COUNT(BIN_COUNT), .BIN_STEP_NS(BIN_STEP_NS)) u_back (
    .clk, .rst_n, .q_head(head), .q_empty(empty), .q_pop(pop), .out_valid,
    .out_stall, .out_total_count, .out_mean_ns, .out_p99_upper_ns, .out_max_ns,
    .out_min_frames, .out_max_frames, .out_over_half_count, .out_over_full_count
  );

endmodule

// File: rtl/lhm_checker.sv
// Port-level checks for the latency histogram monitor, bound to the top.
`timescale 1ns / 1ps
module lhm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_total_count,
  input logic [31:0] out_mean_ns,
  input logic [24:0] out_p99_upper_ns,
  input logic [15:0] out_min_frames,
  input logic [15:0] out_max_frames,
  input logic [31:0] out_over_half_count,
  input logic [31:0] out_over_full_count
);

  // hold a stalled summary word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_count) &&
    $stable(out_mean_ns))
    else $error("stalled summary changed");

  // empty history reads as zeros
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_count == '0 |-> out_mean_ns == '0 &&
    out_p99_upper_ns == '0 && out_min_frames == '0 && out_max_frames == '0)
    else $error("empty summary not zero");

  // frame extremes ordered
  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_count != '0 |-> out_min_frames <= out_max_frames)
    else $error("min frames above max frames");

  // a full-period hit is also a half-period hit
  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_over_full_count <= out_over_half_count &&
    out_over_half_count <= out_total_count)
    else $error("period counters out of order");

endmodule

bind latency_histogram_monitor lhm_checker u_lhm_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_total_count, .out_mean_ns,
  .out_p99_upper_ns, .out_min_frames, .out_max_frames, .out_over_half_count,
  .out_over_full_count
);
